FILE: sv/iffc_pkg.sv
// Package for the int/float format converter.
// Holds the item structs, mode codes and float format constants. No dependencies.
package iffc_pkg;

  localparam int unsigned DataWidth = 64;

  // Conversion direction codes
  typedef enum logic [2:0] {
    ModeU8F32  = 3'd0,
    ModeU8F64  = 3'd1,
    ModeU16F32 = 3'd2,
    ModeU16F64 = 3'd3,
    ModeF32U8  = 3'd4,
    ModeF32U16 = 3'd5,
    ModeF64U8  = 3'd6,
    ModeF64U16 = 3'd7
  } mode_e;

  localparam logic [10:0] F32Bias   = 11'd127;
  localparam logic [10:0] F64Bias   = 11'd1023;
  localparam logic [10:0] F32ExpMax = 11'd255;
  localparam logic [10:0] F64ExpMax = 11'd2047;

  typedef struct packed {
    logic [DataWidth-1:0] source_bits;
    logic                 last_in;
  } in_item_t;

  typedef struct packed {
    logic [DataWidth-1:0] result_bits;
    logic                 out_of_range;
    logic                 last_out;
  } out_item_t;

endpackage

FILE: sv/int_float_format_converter.sv
// Top level of the int/float format converter.
// Depends on iffc_pkg, iffc_int2flt, iffc_flt2int.
//
// Usage:
//   cfg channel (cfg_valid_i/cfg_ready_o/cfg_data_i) writes the 3-bit
//   conversion mode; write it only while the block holds no item.
//   in channel carries source bits and a last marker; out channel returns
//   the converted bits, the clamp flag and the marker.
// Path: an accepted item is registered at the input, converted by one
//   pass of combinational logic, and then registered in the result
//   register, from which it is shown.
// Throughput: one item per cycle while out_ready_i stays high; both stages
//   advance whenever the result register is empty or being drained.
// Reset: clears the mode to u8->f32 and drops both stage valid bits.
// Stall: when out_ready_i is low the result holds, the input stage fills,
//   and then in_ready_o drops until the receiver takes the result.
module int_float_format_converter import iffc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [2:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  mode_e     mode_q;
  in_item_t  src_q;
  logic      src_vld_q;
  out_item_t res_q, res_d;
  logic      res_vld_q;
  logic      adv_res, adv_src;
  logic [DataWidth-1:0] i2f_res, f2i_res, fsrc;
  logic      f2i_flag;

  assign cfg_ready_o = 1'b1;
  assign adv_res     = !res_vld_q || out_ready_i;
  assign adv_src     = !src_vld_q || adv_res;
  assign in_ready_o  = adv_src;
  assign out_valid_o = res_vld_q;
  assign out_item_o  = res_q;

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeU8F32;
    end else if (cfg_valid_i) begin
      mode_q <= mode_e'(cfg_data_i);
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (adv_src) src_vld_q <= in_valid_i;
      if (adv_res) res_vld_q <= src_vld_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (adv_src && in_valid_i) src_q <= in_item_i;
    if (adv_res && src_vld_q) res_q <= res_d;
  end

  iffc_int2flt u_int2flt (
    .value_i  (mode_q[1] ? src_q.source_bits[15:0] : {8'd0, src_q.source_bits[7:0]}),
    .dbl_i    (mode_q[0]),
    .result_o (i2f_res)
  );

  assign fsrc = mode_q[1] ? src_q.source_bits : {32'd0, src_q.source_bits[31:0]};

  iffc_flt2int u_flt2int (
    .bits_i   (fsrc),
    .dbl_i    (mode_q[1]),
    .wide_i   (mode_q[0]),
    .result_o (f2i_res),
    .flag_o   (f2i_flag)
  );

  // Result selection
  always_comb begin
    res_d.last_out = src_q.last_in;
    if (mode_q[2]) begin
      res_d.result_bits  = f2i_res;
      res_d.out_of_range = f2i_flag;
    end else begin
      res_d.result_bits  = i2f_res;
      res_d.out_of_range = 1'b0;
    end
  end

endmodule

FILE: sv/iffc_int2flt.sv
// Unsigned 16-bit integer to exact binary32/binary64 bit pattern.
// Depends on iffc_pkg.
module iffc_int2flt import iffc_pkg::*; (
  input  logic [15:0]          value_i,
  input  logic                 dbl_i,
  output logic [DataWidth-1:0] result_o
);

  logic [3:0]  msb;
  logic [15:0] frac16;
  logic [10:0] expo;

  // Leading one position, then left-justify the bits below it
  always_comb begin
    msb = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (value_i[i]) msb = 4'(i);
    end
    frac16 = value_i << (5'd16 - {1'b0, msb});
    expo   = (dbl_i ? F64Bias : F32Bias) + {7'd0, msb};
    if (value_i == 16'd0) begin
      result_o = '0;
    end else if (dbl_i) begin
      result_o = {1'b0, expo, frac16, 36'd0};
    end else begin
      result_o = {32'd0, 1'b0, expo[7:0], frac16, 7'd0};
    end
  end

endmodule

FILE: sv/iffc_flt2int.sv
// Binary32/binary64 to unsigned 8/16-bit integer, truncating, with clamp flag.
// Depends on iffc_pkg.
module iffc_flt2int import iffc_pkg::*; (
  input  logic [DataWidth-1:0] bits_i,
  input  logic                 dbl_i,
  input  logic                 wide_i,
  output logic [DataWidth-1:0] result_o,
  output logic                 flag_o
);

  logic [10:0] expo, bias, expmax;
  logic        neg, frac_nz;
  logic [16:0] top;   // hidden one and 16 leading fraction bits
  logic [10:0] k;
  logic [15:0] maxv, val;

  always_comb begin
    if (dbl_i) begin
      expo    = bits_i[62:52];
      neg     = bits_i[63];
      frac_nz = |bits_i[51:0];
      top     = {1'b1, bits_i[51:36]};
      bias    = F64Bias;
      expmax  = F64ExpMax;
    end else begin
      expo    = {3'd0, bits_i[30:23]};
      neg     = bits_i[31];
      frac_nz = |bits_i[22:0];
      top     = {1'b1, bits_i[22:7]};
      bias    = F32Bias;
      expmax  = F32ExpMax;
    end
    maxv = wide_i ? 16'hFFFF : 16'h00FF;
    k    = expo - bias;
    val  = 16'(top >> (5'd16 - k[4:0]));
    flag_o = 1'b0;
    // Special cases in priority order: NaN, below one, negative, too large or infinite
    if (expo == expmax && frac_nz) begin
      flag_o = 1'b1;
      val    = '0;
    end else if (expo < bias) begin
      val = '0;
    end else if (neg) begin
      flag_o = 1'b1;
      val    = '0;
    end else if (expo == expmax || k >= (wide_i ? 11'd16 : 11'd8)) begin
      flag_o = 1'b1;
      val    = maxv;
    end else begin
      val = val & maxv;
    end
    result_o = {48'd0, val};
  end

endmodule

FILE: sv/iffc_checker.sv
// Port-level checker for the int/float format converter, bound to the top.
// Depends on iffc_pkg.
module iffc_checker import iffc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed under stall");

  // After an item is accepted while out_ready_i is high, a valid output is checked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && out_ready_i |=> ##1 out_valid_o)
    else $error("item lost");

  // Input stalls only while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("spurious input stall");

endmodule

bind int_float_format_converter iffc_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_item_o
);
